// File: rtl/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// shared types, register indexes, event codes and byte-wide crc steps for the
// crc checked packet deframer
// ----------------------------------------------------------------------------
`default_nettype none

package cpd_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PREFIX      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_CRC_POLY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_CRC_INIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_CRC_POLY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_CRC_INIT = 3'd4;

  localparam logic [7:0]  RST_SYNC_PREFIX      = 8'hAA;
  localparam logic [7:0]  RST_HEADER_CRC_POLY  = 8'h37;
  localparam logic [7:0]  RST_HEADER_CRC_INIT  = 8'h42;
  localparam logic [15:0] RST_PAYLOAD_CRC_POLY = 16'h3D65;
  localparam logic [15:0] RST_PAYLOAD_CRC_INIT = 16'h1337;

  // largest payload length that a header may announce
  localparam logic [7:0] MAX_PAYLOAD = 8'd127;

  typedef enum logic [2:0] {
    EV_HDR     = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_REJECT  = 3'd2,
    EV_GOOD    = 3'd3,
    EV_BAD     = 3'd4
  } event_t;

  typedef struct packed {
    logic [7:0]  sync_prefix;
    logic [7:0]  header_crc_poly;
    logic [7:0]  header_crc_init;
    logic [15:0] payload_crc_poly;
    logic [15:0] payload_crc_init;
  } cfg_t;

  typedef struct packed {
    event_t     ev;
    logic [7:0] byte_index;
    logic [6:0] payload_length;
  } res_t;

  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b,
                                           logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b,
                                             logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// cpd_cfg_regs
// configuration register file written through the cfg channel
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cpd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output cpd_pkg::cfg_t                         cfg
);

  cpd_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_prefix      <= cpd_pkg::RST_SYNC_PREFIX;
      cfg_r.header_crc_poly  <= cpd_pkg::RST_HEADER_CRC_POLY;
      cfg_r.header_crc_init  <= cpd_pkg::RST_HEADER_CRC_INIT;
      cfg_r.payload_crc_poly <= cpd_pkg::RST_PAYLOAD_CRC_POLY;
      cfg_r.payload_crc_init <= cpd_pkg::RST_PAYLOAD_CRC_INIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cpd_pkg::CFG_SYNC_PREFIX:      cfg_r.sync_prefix      <= cfg_wdata[7:0];
        cpd_pkg::CFG_HEADER_CRC_POLY:  cfg_r.header_crc_poly  <= cfg_wdata[7:0];
        cpd_pkg::CFG_HEADER_CRC_INIT:  cfg_r.header_crc_init  <= cfg_wdata[7:0];
        cpd_pkg::CFG_PAYLOAD_CRC_POLY: cfg_r.payload_crc_poly <= cfg_wdata;
        cpd_pkg::CFG_PAYLOAD_CRC_INIT: cfg_r.payload_crc_init <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/cpd_frame_fsm.sv
// ----------------------------------------------------------------------------
// cpd_frame_fsm
// header hunt, length and crc checks, body counting and crc-16 residue check;
// classifies one word per take
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_frame_fsm (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          take,
  input  wire logic [7:0]    rx_byte,
  input  wire cpd_pkg::cfg_t cfg,
  output cpd_pkg::res_t      res
);

  typedef enum logic [3:0] {
    ST_HUNT = 4'b0001,
    ST_LEN  = 4'b0010,
    ST_HCRC = 4'b0100,
    ST_BODY = 4'b1000
  } state_t;

  state_t      st_r, st_nxt;
  logic [6:0]  length_r, length_nxt;
  logic [7:0]  body_count_r, body_count_nxt;
  logic [7:0]  header_crc_r, header_crc_nxt;
  logic [15:0] body_crc_r, body_crc_nxt;

  logic [7:0]  hcrc_first;
  logic [7:0]  hcrc_next;
  logic [15:0] bcrc_next;
  logic [7:0]  len_ext;

  assign hcrc_first = cpd_pkg::crc8_step(cfg.header_crc_init, rx_byte, cfg.header_crc_poly);
  assign hcrc_next  = cpd_pkg::crc8_step(header_crc_r, rx_byte, cfg.header_crc_poly);
  assign bcrc_next  = cpd_pkg::crc16_step(body_crc_r, rx_byte, cfg.payload_crc_poly);
  assign len_ext    = {1'b0, length_r};

  always_comb begin
    st_nxt             = st_r;
    length_nxt         = length_r;
    body_count_nxt     = body_count_r;
    header_crc_nxt     = header_crc_r;
    body_crc_nxt       = body_crc_r;
    res.ev             = cpd_pkg::EV_HDR;
    res.byte_index     = 8'd0;
    res.payload_length = length_r;
    unique case (st_r)
      ST_HUNT: begin
        if (rx_byte == cfg.sync_prefix) begin
          header_crc_nxt = hcrc_first;
          st_nxt         = ST_LEN;
        end else begin
          res.ev = cpd_pkg::EV_REJECT;
        end
      end
      ST_LEN: begin
        if (rx_byte[7] || (rx_byte > cpd_pkg::MAX_PAYLOAD)) begin
          res.ev = cpd_pkg::EV_REJECT;
          st_nxt = ST_HUNT;
        end else begin
          header_crc_nxt     = hcrc_next;
          length_nxt         = rx_byte[6:0];
          res.payload_length = rx_byte[6:0];
          st_nxt             = ST_HCRC;
        end
      end
      ST_HCRC: begin
        if (hcrc_next != 8'd0) begin
          res.ev         = cpd_pkg::EV_REJECT;
          length_nxt     = 7'd0;
          st_nxt         = ST_HUNT;
        end else begin
          header_crc_nxt = hcrc_next;
          body_count_nxt = 8'd0;
          body_crc_nxt   = cfg.payload_crc_init;
          st_nxt         = ST_BODY;
        end
      end
      ST_BODY: begin
        res.byte_index = body_count_r;
        body_crc_nxt   = bcrc_next;
        if (body_count_r < len_ext) begin
          res.ev         = cpd_pkg::EV_PAYLOAD;
          body_count_nxt = body_count_r + 8'd1;
        end else if (body_count_r == len_ext) begin
          body_count_nxt = body_count_r + 8'd1;
        end else begin
          res.ev         = (bcrc_next == 16'd0) ? cpd_pkg::EV_GOOD : cpd_pkg::EV_BAD;
          length_nxt     = 7'd0;
          body_count_nxt = 8'd0;
          st_nxt         = ST_HUNT;
        end
      end
      default: begin
        st_nxt         = ST_HUNT;
        length_nxt     = 7'd0;
        body_count_nxt = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_HUNT;
      length_r     <= 7'd0;
      body_count_r <= 8'd0;
    end else if (take) begin
      st_r         <= st_nxt;
      length_r     <= length_nxt;
      body_count_r <= body_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      header_crc_r <= header_crc_nxt;
      body_crc_r   <= body_crc_nxt;
    end
  end

  a_len_clear_in_header: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_HUNT || st_r == ST_LEN) |-> (length_r == 7'd0))
    else $error("length held outside a packet");

  a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, length_r} <= cpd_pkg::MAX_PAYLOAD))
    else $error("stored length above maximum");

  a_body_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_BODY) |-> (body_count_r <= len_ext + 8'd1))
    else $error("body count ran past trailer");

  a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (res.ev == cpd_pkg::EV_GOOD || res.ev == cpd_pkg::EV_BAD))
    |=> (st_r == ST_HUNT && body_count_r == 8'd0))
    else $error("no restart after packet end");

endmodule

`default_nettype wire

// File: rtl/crc_checked_packet_deframer.sv
// ----------------------------------------------------------------------------
// crc_checked_packet_deframer
// byte stream deframer: sync prefix, length and crc-8 checked header, then
// payload and crc-16 trailer with a good or bad report on the last byte
//
//   channel  handshake            payload
//   in       in_valid / in_stall  in_rx_byte
//   out      out_valid/ out_stall out_event_res, out_data_byte,
//                                 out_byte_index, out_payload_length
//   cfg      cfg_valid/ cfg_ready cfg_index, cfg_wdata
//
// one word per cycle sustained while out_stall is low; a taken word passes the
// input register, then one pass of crc and state logic into the output register
// a stalled output holds its word while the input register still takes one more
// synchronous active-low reset restores register defaults and the hunt state
// ----------------------------------------------------------------------------
`default_nettype none

module crc_checked_packet_deframer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [2:0]                          out_event_res,
  output logic [7:0]                          out_data_byte,
  output logic [7:0]                          out_byte_index,
  output logic [6:0]                          out_payload_length,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  cpd_pkg::cfg_t cfg;
  cpd_pkg::res_t res;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  logic [2:0] out_event_r;
  logic [7:0] out_byte_r;
  logic [7:0] out_index_r;
  logic [6:0] out_length_r;
  logic       adv;
  logic       take;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign take     = s1_valid_r && adv;

  cpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cpd_frame_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (s1_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_rx_byte;
    end
    if (take) begin
      out_event_r  <= res.ev;
      out_byte_r   <= s1_byte_r;
      out_index_r  <= res.byte_index;
      out_length_r <= res.payload_length;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = out_event_r;
  assign out_data_byte      = out_byte_r;
  assign out_byte_index     = out_index_r;
  assign out_payload_length = out_length_r;

endmodule

`default_nettype wire
